// ===== hw/rtl/bb3_pkg.sv =====
// Shared types, constants and reciprocal table of the 3x3 edge-aware box blur.
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int NUM_LINES     = 3;

    localparam int CH_W      = 8;
    localparam int PIX_W     = 3 * CH_W;
    localparam int FW_W      = 11;
    localparam int FH_W      = 12;
    localparam int ROW_W     = 12;
    localparam int OUT_COL_W = 10;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 12;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [FW_W-1:0] FW_RESET = 11'd640;
    localparam logic [FH_W-1:0] FH_RESET = 12'd480;

    localparam int SUM_W     = 12;
    localparam int CNT_W     = 4;
    localparam int RCP_W     = 17;
    localparam int RCP_SHIFT = 16;
    localparam int PROD_W    = SUM_W + RCP_W;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } pixel_t;

    // [column][row]; index 0 is the newest column / newest row
    typedef pixel_t [2:0][2:0] window_t;

    typedef struct packed {
        logic [2:0]           row_mask;
        logic [2:0]           col_mask;
        logic [ROW_W-1:0]     row;
        logic [OUT_COL_W-1:0] col;
        logic                 run_last;
        logic                 frame_last;
    } req_t;

    function automatic logic [1:0] ones3(input logic [2:0] m);
        return {1'b0, m[0]} + {1'b0, m[1]} + {1'b0, m[2]};
    endfunction

    // ceil(2^16 / count); exact floor division for sums up to 9 * 255
    function automatic logic [RCP_W-1:0] recip(input logic [2:0] row_mask,
                                               input logic [2:0] col_mask);
        logic [CNT_W-1:0] cnt;
        cnt = {2'b00, ones3(row_mask)} * {2'b00, ones3(col_mask)};
        case (cnt)
            4'd1:    return 17'd65536;
            4'd2:    return 17'd32768;
            4'd3:    return 17'd21846;
            4'd4:    return 17'd16384;
            4'd6:    return 17'd10923;
            4'd9:    return 17'd7282;
            default: return '0;
        endcase
    endfunction

endpackage

// ===== hw/rtl/bb3_ram.sv =====
// Generic simple dual-read RAM: one write port, two registered read ports.
module bb3_ram #(
    parameter int WIDTH = bb3_pkg::PIX_W,
    parameter int DEPTH = bb3_pkg::NUM_LINES * bb3_pkg::MAX_WIDTH_DEF,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// Frame counters, configuration, line store access, 3x3 window and result sequencing.
module bb3_ctrl #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF,
    localparam int COL_W    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
    localparam int AW       = $clog2(bb3_pkg::NUM_LINES * MAX_WIDTH)
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  logic [bb3_pkg::CH_W-1:0]        in_red,
    input  logic [bb3_pkg::CH_W-1:0]        in_green,
    input  logic [bb3_pkg::CH_W-1:0]        in_blue,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]  cfg_data,
    output logic                            ram_we,
    output logic [AW-1:0]                   ram_waddr,
    output logic [bb3_pkg::PIX_W-1:0]       ram_wdata,
    output logic [AW-1:0]                   ram_raddr_a,
    output logic [AW-1:0]                   ram_raddr_b,
    input  logic [bb3_pkg::PIX_W-1:0]       ram_rdata_a,
    input  logic [bb3_pkg::PIX_W-1:0]       ram_rdata_b,
    output logic                            req_valid,
    input  logic                            req_ready,
    output bb3_pkg::req_t                   req,
    output bb3_pkg::window_t                window
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_LOAD  = 2'd1;
    localparam logic [1:0] ST_ISSUE = 2'd2;

    localparam logic [1:0] SEL_UP_LEFT  = 2'd0;
    localparam logic [1:0] SEL_UP_HERE  = 2'd1;
    localparam logic [1:0] SEL_LOW_LEFT = 2'd2;
    localparam logic [1:0] SEL_LOW_HERE = 2'd3;

    logic [1:0]                  state_reg, state_next;
    logic [3:0]                  pend_reg, pend_next;
    logic [bb3_pkg::FW_W-1:0]    fw_reg, fw_next;
    logic [bb3_pkg::FH_W-1:0]    fh_reg, fh_next;
    logic [bb3_pkg::ROW_W-1:0]   row_reg, row_next;
    logic [COL_W-1:0]            col_reg, col_next;
    logic [1:0]                  line_reg, line_next;
    logic [bb3_pkg::ROW_W-1:0]   cur_row_reg;
    logic [COL_W-1:0]            cur_col_reg;
    bb3_pkg::pixel_t             pix_reg;
    bb3_pkg::window_t            win_reg, win_next;

    logic                        in_fire, cfg_fire, restart;
    logic [COL_W-1:0]            last_col;
    logic [bb3_pkg::ROW_W-1:0]   last_row;
    logic [1:0]                  line_prev1, line_prev2;
    logic                        rge1, rge2, cge1, cge2, rlast, clast;
    logic [3:0]                  load_pend;
    logic [1:0]                  issue_sel;
    logic [3:0]                  issue_onehot;
    logic                        last_req, upper, left;
    logic [COL_W-1:0]            req_col_full;

    function automatic logic [AW-1:0] line_addr(input logic [1:0] line_sel,
                                                input logic [COL_W-1:0] col);
        logic [AW-1:0] base;
        case (line_sel)
            2'd0:    base = '0;
            2'd1:    base = AW'(MAX_WIDTH);
            default: base = AW'(2 * MAX_WIDTH);
        endcase
        return base + AW'(col);
    endfunction

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        if (fw_reg == '0)
        begin
            last_col = '0;
        end
        else if (32'(fw_reg) >= 32'(MAX_WIDTH))
        begin
            last_col = COL_W'(MAX_WIDTH - 1);
        end
        else
        begin
            last_col = COL_W'(32'(fw_reg) - 32'd1);
        end
        last_row = (fh_reg == '0) ? '0 : fh_reg - bb3_pkg::ROW_W'(1);
    end

    always_comb
    begin
        case (line_reg)
            2'd0:
            begin
                line_prev1 = 2'd2;
                line_prev2 = 2'd1;
            end
            2'd1:
            begin
                line_prev1 = 2'd0;
                line_prev2 = 2'd2;
            end
            default:
            begin
                line_prev1 = 2'd1;
                line_prev2 = 2'd0;
            end
        endcase
    end

    assign ram_we      = in_fire;
    assign ram_waddr   = line_addr(line_reg, col_reg);
    assign ram_wdata   = {in_red, in_green, in_blue};
    assign ram_raddr_a = line_addr(line_prev1, col_reg);
    assign ram_raddr_b = line_addr(line_prev2, col_reg);

    // position of the item in flight
    assign rge1  = cur_row_reg != '0;
    assign rge2  = cur_row_reg > bb3_pkg::ROW_W'(1);
    assign cge1  = cur_col_reg != '0;
    assign cge2  = cur_col_reg > COL_W'(1);
    assign rlast = cur_row_reg == last_row;
    assign clast = cur_col_reg == last_col;

    assign load_pend = {rlast && clast, rlast && cge1, rge1 && clast, rge1 && cge1};

    always_comb
    begin
        if (pend_reg[0])
        begin
            issue_sel = SEL_UP_LEFT;
        end
        else if (pend_reg[1])
        begin
            issue_sel = SEL_UP_HERE;
        end
        else if (pend_reg[2])
        begin
            issue_sel = SEL_LOW_LEFT;
        end
        else
        begin
            issue_sel = SEL_LOW_HERE;
        end
    end

    assign issue_onehot = 4'd1 << issue_sel;
    assign last_req     = (pend_reg & ~issue_onehot) == '0;
    assign upper        = (issue_sel == SEL_UP_LEFT) || (issue_sel == SEL_UP_HERE);
    assign left         = (issue_sel == SEL_UP_LEFT) || (issue_sel == SEL_LOW_LEFT);
    assign req_col_full = left ? cur_col_reg - COL_W'(1) : cur_col_reg;

    assign req_valid      = state_reg == ST_ISSUE;
    assign req.row        = upper ? cur_row_reg - bb3_pkg::ROW_W'(1) : cur_row_reg;
    assign req.col        = bb3_pkg::OUT_COL_W'(req_col_full);
    assign req.row_mask   = upper ? {rge2, 1'b1, 1'b1} : {1'b0, rge1, 1'b1};
    assign req.col_mask   = left ? {cge2, 1'b1, 1'b1} : {1'b0, cge1, 1'b1};
    assign req.run_last   = last_req;
    assign req.frame_last = issue_sel == SEL_LOW_HERE;
    assign window         = win_reg;

    // take a pixel while idle, or as the last result of the current one leaves
    assign in_ready = (state_reg == ST_IDLE) ||
                      ((state_reg == ST_ISSUE) && req_ready && last_req);

    always_comb
    begin
        state_next = state_reg;
        pend_next  = pend_reg;
        win_next   = win_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                win_next[2]    = win_reg[1];
                win_next[1]    = win_reg[0];
                win_next[0][0] = pix_reg;
                win_next[0][1] = bb3_pkg::pixel_t'(ram_rdata_a);
                win_next[0][2] = bb3_pkg::pixel_t'(ram_rdata_b);
                pend_next      = load_pend;
                state_next     = (load_pend != '0) ? ST_ISSUE : ST_IDLE;
            end
            ST_ISSUE:
            begin
                if (req_ready)
                begin
                    pend_next = pend_reg & ~issue_onehot;
                    if (last_req)
                    begin
                        state_next = in_fire ? ST_LOAD : ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fw_next   = fw_reg;
        fh_next   = fh_reg;
        row_next  = row_reg;
        col_next  = col_reg;
        line_next = line_reg;
        restart   = 1'b0;
        if (cfg_fire)
        begin
            case (cfg_index)
                bb3_pkg::CFG_FRAME_WIDTH:
                begin
                    fw_next = cfg_data[bb3_pkg::FW_W-1:0];
                    restart = 1'b1;
                end
                bb3_pkg::CFG_FRAME_HEIGHT:
                begin
                    fh_next = cfg_data[bb3_pkg::FH_W-1:0];
                    restart = 1'b1;
                end
                default:
                begin
                    restart = 1'b0;
                end
            endcase
        end
        if (restart)
        begin
            row_next  = '0;
            col_next  = '0;
            line_next = 2'd0;
        end
        else if (in_fire)
        begin
            if (col_reg == last_col)
            begin
                col_next = '0;
                if (row_reg == last_row)
                begin
                    row_next  = '0;
                    line_next = 2'd0;
                end
                else
                begin
                    row_next  = row_reg + bb3_pkg::ROW_W'(1);
                    line_next = (line_reg == 2'd2) ? 2'd0 : line_reg + 2'd1;
                end
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            pend_reg  <= '0;
            fw_reg    <= bb3_pkg::FW_RESET;
            fh_reg    <= bb3_pkg::FH_RESET;
            row_reg   <= '0;
            col_reg   <= '0;
            line_reg  <= 2'd0;
        end
        else
        begin
            state_reg <= state_next;
            pend_reg  <= pend_next;
            fw_reg    <= fw_next;
            fh_reg    <= fh_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            line_reg  <= line_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cur_row_reg <= row_reg;
            cur_col_reg <= col_reg;
            pix_reg     <= bb3_pkg::pixel_t'({in_red, in_green, in_blue});
        end
        win_reg <= win_next;
    end

    a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_LOAD)
        else $error("accepted pixel did not enter the load step");

    a_corner_only: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ISSUE) && pend_reg[3] |-> rlast && clast)
        else $error("bottom-right result pending away from frame corner");

    a_cfg_restart: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready &&
        ((cfg_index == bb3_pkg::CFG_FRAME_WIDTH) || (cfg_index == bb3_pkg::CFG_FRAME_HEIGHT))
        |=> (row_reg == '0) && (col_reg == '0) && (line_reg == 2'd0))
        else $error("configuration write did not restart the frame");

endmodule

// ===== hw/rtl/bb3_avg.sv =====
// Two-stage averaging pipeline: masked 3x3 sums, then reciprocal multiply into the output register.
module bb3_avg (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               req_valid,
    output logic                               req_ready,
    input  bb3_pkg::req_t                      req,
    input  bb3_pkg::window_t                   window,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bb3_pkg::CH_W-1:0]           out_red,
    output logic [bb3_pkg::CH_W-1:0]           out_green,
    output logic [bb3_pkg::CH_W-1:0]           out_blue,
    output logic [bb3_pkg::ROW_W-1:0]          out_row,
    output logic [bb3_pkg::OUT_COL_W-1:0]      out_col,
    output logic                               run_last,
    output logic                               frame_last
);

    bb3_pkg::window_t                     masked;
    logic [2:0][bb3_pkg::SUM_W-1:0]       col_red, col_green, col_blue;
    logic [bb3_pkg::SUM_W-1:0]            sum_red, sum_green, sum_blue;
    logic [bb3_pkg::PROD_W-1:0]           prod_red, prod_green, prod_blue;

    logic                                 s1_valid_reg;
    logic [bb3_pkg::SUM_W-1:0]            s1_red_reg, s1_green_reg, s1_blue_reg;
    logic [bb3_pkg::RCP_W-1:0]            s1_recip_reg;
    bb3_pkg::req_t                        s1_req_reg;

    logic                                 out_valid_reg;
    logic [bb3_pkg::CH_W-1:0]             out_red_reg, out_green_reg, out_blue_reg;
    bb3_pkg::req_t                        out_req_reg;

    logic                                 out_move, s1_ready, req_fire;

    assign out_move  = !out_valid_reg || out_ready;
    assign s1_ready  = !s1_valid_reg || out_move;
    assign req_ready = s1_ready;
    assign req_fire  = req_valid && s1_ready;

    always_comb
    begin
        for (int j = 0; j < 3; j++)
        begin
            for (int i = 0; i < 3; i++)
            begin
                masked[j][i] = (req.row_mask[i] && req.col_mask[j]) ? window[j][i] : '0;
            end
            col_red[j]   = bb3_pkg::SUM_W'(masked[j][0].red) +
                           bb3_pkg::SUM_W'(masked[j][1].red) +
                           bb3_pkg::SUM_W'(masked[j][2].red);
            col_green[j] = bb3_pkg::SUM_W'(masked[j][0].green) +
                           bb3_pkg::SUM_W'(masked[j][1].green) +
                           bb3_pkg::SUM_W'(masked[j][2].green);
            col_blue[j]  = bb3_pkg::SUM_W'(masked[j][0].blue) +
                           bb3_pkg::SUM_W'(masked[j][1].blue) +
                           bb3_pkg::SUM_W'(masked[j][2].blue);
        end
        sum_red   = col_red[0] + col_red[1] + col_red[2];
        sum_green = col_green[0] + col_green[1] + col_green[2];
        sum_blue  = col_blue[0] + col_blue[1] + col_blue[2];
    end

    assign prod_red   = bb3_pkg::PROD_W'(s1_red_reg) * bb3_pkg::PROD_W'(s1_recip_reg);
    assign prod_green = bb3_pkg::PROD_W'(s1_green_reg) * bb3_pkg::PROD_W'(s1_recip_reg);
    assign prod_blue  = bb3_pkg::PROD_W'(s1_blue_reg) * bb3_pkg::PROD_W'(s1_recip_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= req_valid;
            end
            if (out_move)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_red_reg   <= sum_red;
            s1_green_reg <= sum_green;
            s1_blue_reg  <= sum_blue;
            s1_recip_reg <= bb3_pkg::recip(req.row_mask, req.col_mask);
            s1_req_reg   <= req;
        end
        if (out_move && s1_valid_reg)
        begin
            out_red_reg   <= prod_red[bb3_pkg::RCP_SHIFT +: bb3_pkg::CH_W];
            out_green_reg <= prod_green[bb3_pkg::RCP_SHIFT +: bb3_pkg::CH_W];
            out_blue_reg  <= prod_blue[bb3_pkg::RCP_SHIFT +: bb3_pkg::CH_W];
            out_req_reg   <= s1_req_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_red    = out_red_reg;
    assign out_green  = out_green_reg;
    assign out_blue   = out_blue_reg;
    assign out_row    = out_req_reg.row;
    assign out_col    = out_req_reg.col;
    assign run_last   = out_req_reg.run_last;
    assign frame_last = out_req_reg.frame_last;

    a_center_in: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |-> req.row_mask[0] && req.col_mask[0])
        else $error("request excludes its own center row or column");

    a_recip_known: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg |-> s1_recip_reg != '0)
        else $error("neighbor count outside the reciprocal table");

    a_frame_last_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && frame_last |-> run_last)
        else $error("frame end not marked as end of run");

endmodule

// ===== hw/rtl/box_blur_3x3_edge_aware.sv =====
// Top level of the streaming 3x3 edge-aware RGB box blur.
// Input channel (in_valid/in_ready, in_red/in_green/in_blue) takes pixels in raster order;
// output channel (out_valid/out_ready) returns blurred pixels tagged with out_row, out_col,
// run_last (last result caused by an input transfer) and frame_last (bottom-right pixel).
// Configuration channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes frame_width (0)
// and frame_height (1); either write restarts the frame. cfg_ready is always high.
// The first result of an input transfer passes the load step, the issue step, the sum stage and
// the output register; further results of the same transfer are issued one after another.
// An input causes zero to four results, four only at the bottom-right pixel; the next input is
// taken as the last result of the current one enters the averaging pipeline. The single request
// path into that pipeline and the registered line-store read set this pace.
// Reset sets the frame to 640 x 480 and the position to the top-left pixel; the line store
// is not cleared, since a frame only reads lines it has already written.
// When the receiver stalls, the output register and the sum stage hold two results, then
// result issue stops and in_ready drops until the pending results drain.
module box_blur_3x3_edge_aware #(
    parameter int MAX_WIDTH = bb3_pkg::MAX_WIDTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [bb3_pkg::CH_W-1:0]           in_red,
    input  logic [bb3_pkg::CH_W-1:0]           in_green,
    input  logic [bb3_pkg::CH_W-1:0]           in_blue,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [bb3_pkg::CH_W-1:0]           out_red,
    output logic [bb3_pkg::CH_W-1:0]           out_green,
    output logic [bb3_pkg::CH_W-1:0]           out_blue,
    output logic [bb3_pkg::ROW_W-1:0]          out_row,
    output logic [bb3_pkg::OUT_COL_W-1:0]      out_col,
    output logic                               run_last,
    output logic                               frame_last,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [bb3_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bb3_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int DEPTH = bb3_pkg::NUM_LINES * MAX_WIDTH;
    localparam int AW    = $clog2(DEPTH);

    logic                          ram_we;
    logic [AW-1:0]                 ram_waddr, ram_raddr_a, ram_raddr_b;
    logic [bb3_pkg::PIX_W-1:0]     ram_wdata, ram_rdata_a, ram_rdata_b;
    logic                          req_valid, req_ready;
    bb3_pkg::req_t                 req;
    bb3_pkg::window_t              window;

    bb3_ram #(
        .WIDTH (bb3_pkg::PIX_W),
        .DEPTH (DEPTH)
    ) u_line_store (
        .clk     (clk),
        .we      (ram_we),
        .waddr   (ram_waddr),
        .wdata   (ram_wdata),
        .raddr_a (ram_raddr_a),
        .rdata_a (ram_rdata_a),
        .raddr_b (ram_raddr_b),
        .rdata_b (ram_rdata_b)
    );

    bb3_ctrl #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_red      (in_red),
        .in_green    (in_green),
        .in_blue     (in_blue),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .ram_raddr_a (ram_raddr_a),
        .ram_raddr_b (ram_raddr_b),
        .ram_rdata_a (ram_rdata_a),
        .ram_rdata_b (ram_rdata_b),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .window      (window)
    );

    bb3_avg u_avg (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (req_valid),
        .req_ready  (req_ready),
        .req        (req),
        .window     (window),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_red    (out_red),
        .out_green  (out_green),
        .out_blue   (out_blue),
        .out_row    (out_row),
        .out_col    (out_col),
        .run_last   (run_last),
        .frame_last (frame_last)
    );

endmodule
